// ===== rtl/background_reconstruction_vote_core_assert.svh =====
// Assertion helpers for the background vote core.
// They expect clk and arst_n in the scope where they are used.
`ifndef BACKGROUND_RECONSTRUCTION_VOTE_CORE_ASSERT_SVH
`define BACKGROUND_RECONSTRUCTION_VOTE_CORE_ASSERT_SVH

// Check a property in the same cycle as its trigger.
`define BRV_ASSERT_NOW(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error(msg);

// Check a property in the cycle after its trigger.
`define BRV_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/brv_pkg.sv =====
package brv_pkg;

	localparam int FRAME_PIXELS_DEF = 65536;
	localparam int COUNT_WIDTH_DEF  = 8;

	// Configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_TOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL  = 2'd1;

	localparam logic [7:0] CHANGE_TOL_RST = 8'd20;
	localparam logic [7:0] MATCH_TOL_RST  = 8'd20;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} bgr_t;

	typedef struct packed {
		logic [15:0] pixel_index;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic        first_frame;
		logic        last_frame;
	} pix_item_t;

	typedef struct packed {
		logic [15:0] out_index;
		logic [7:0]  bg_blue;
		logic [7:0]  bg_green;
		logic [7:0]  bg_red;
		logic        was_changed;
	} bg_item_t;

	function automatic logic [7:0] absdiff8(logic [7:0] a, logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// True when some channel differs by more than tol
	function automatic logic any_above(bgr_t a, bgr_t b, logic [7:0] tol);
		return (absdiff8(a.blue, b.blue) > tol) ||
			(absdiff8(a.green, b.green) > tol) ||
			(absdiff8(a.red, b.red) > tol);
	endfunction

	// True when every channel differs by less than tol
	function automatic logic all_below(bgr_t a, bgr_t b, logic [7:0] tol);
		return (absdiff8(a.blue, b.blue) < tol) &&
			(absdiff8(a.green, b.green) < tol) &&
			(absdiff8(a.red, b.red) < tol);
	endfunction

endpackage

// ===== rtl/background_reconstruction_vote_core.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------
// pixel in | pix_valid / pix_ready     | pix (brv_pkg::pix_item_t)
// result   | bg_valid / bg_ready       | bg (brv_pkg::bg_item_t)
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle unless stalled; after stage two a last-frame result is registered.
// The per-pixel record lives in one memory with one read and one write port; a record
// change reaches the next item of the same pixel through two forwarding registers.
// Reset clears valid bits and tolerances only; the record memory needs no clearing pass.
// Input stalls only while a result sits in the output register, the item in stage two
// has a result too, and the result side is not ready.
module background_reconstruction_vote_core #(
	parameter int FRAME_PIXELS = brv_pkg::FRAME_PIXELS_DEF,
	parameter int COUNT_WIDTH  = brv_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  brv_pkg::pix_item_t            pix,
	output logic                          bg_valid,
	input  logic                          bg_ready,
	output brv_pkg::bg_item_t             bg,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [brv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import brv_pkg::*;

	localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

	typedef struct packed {
		bgr_t                   prev;
		bgr_t                   cand1;
		bgr_t                   cand2;
		logic                   has2;
		logic [COUNT_WIDTH-1:0] cnt1;
		logic [COUNT_WIDTH-1:0] cnt2;
		logic                   changed;
	} rec_t;

	logic [7:0] change_tol_q;
	logic [7:0] match_tol_q;

	rec_t mem_q [FRAME_PIXELS];

	logic              adv;
	logic [31:0]       idx_ext;
	logic [ADDR_W-1:0] pix_addr;
	logic              in_range;

	logic              valid_s1;
	logic              first_s1;
	logic              last_s1;
	bgr_t              px_s1;
	logic [15:0]       idx_s1;
	logic [ADDR_W-1:0] addr_s1;
	rec_t              rd_s1;

	logic              valid_s2;
	logic              last_s2;
	logic [15:0]       idx_s2;
	logic [ADDR_W-1:0] addr_s2;
	rec_t              rec_s2;

	logic              valid_s3;
	logic [ADDR_W-1:0] addr_s3;
	rec_t              rec_s3;

	rec_t     cur;
	rec_t     nxt;
	logic     moved;
	logic     match1;
	logic     match2;
	logic     use_c1;
	logic     load_bg;
	bg_item_t bg_q;
	logic     bg_valid_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			change_tol_q <= CHANGE_TOL_RST;
			match_tol_q  <= MATCH_TOL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CHANGE_TOL: change_tol_q <= cfg_data;
				CFG_MATCH_TOL:  match_tol_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the whole pipeline unless a second result has nowhere to go
	assign adv       = !(valid_s2 && last_s2 && bg_valid_q && !bg_ready);
	assign pix_ready = adv;

	assign idx_ext  = 32'(pix.pixel_index);
	assign pix_addr = idx_ext[ADDR_W-1:0];
	assign in_range = idx_ext < 32'(FRAME_PIXELS);

	// Stage one: take the item, drop out-of-range positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_valid && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= pix.first_frame;
			last_s1  <= pix.last_frame;
			px_s1    <= '{red: pix.red, green: pix.green, blue: pix.blue};
			idx_s1   <= pix.pixel_index;
			addr_s1  <= pix_addr;
		end
	end

	// Record memory: read on entry, write when stage two moves on
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= mem_q[pix_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			mem_q[addr_s2] <= rec_s2;
		end
	end

	// Stage two logic: forward newer records, vote, update
	always_comb begin
		if (valid_s2 && addr_s2 == addr_s1) begin
			cur = rec_s2;
		end else if (valid_s3 && addr_s3 == addr_s1) begin
			cur = rec_s3;
		end else begin
			cur = rd_s1;
		end

		moved  = any_above(px_s1, cur.prev, change_tol_q);
		match1 = all_below(cur.cand1, px_s1, match_tol_q);
		match2 = cur.has2 && all_below(cur.cand2, px_s1, match_tol_q);

		nxt = cur;
		if (first_s1) begin
			nxt.prev    = px_s1;
			nxt.cand1   = px_s1;
			nxt.cand2   = '0;
			nxt.has2    = 1'b0;
			nxt.cnt1    = '0;
			nxt.cnt2    = '0;
			nxt.changed = 1'b0;
		end else begin
			nxt.changed = cur.changed || moved;
			nxt.prev    = px_s1;
			priority if (match1) begin
				if (cur.cnt1 != {COUNT_WIDTH{1'b1}}) begin
					nxt.cnt1 = cur.cnt1 + 1'b1;
				end
			end else if (match2) begin
				if (cur.cnt2 != {COUNT_WIDTH{1'b1}}) begin
					nxt.cnt2 = cur.cnt2 + 1'b1;
				end
			end else begin
				nxt.cand2 = px_s1;
				nxt.has2  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			idx_s2  <= idx_s1;
			addr_s2 <= addr_s1;
			rec_s2  <= nxt;
			addr_s3 <= addr_s2;
			rec_s3  <= rec_s2;
		end
	end

	// Stage three: pick the background and hold the result
	assign use_c1  = !rec_s2.changed || (rec_s2.cnt1 >= rec_s2.cnt2);
	assign load_bg = adv && valid_s2 && last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_valid_q <= 1'b0;
		end else if (load_bg) begin
			bg_valid_q <= 1'b1;
		end else if (bg_ready) begin
			bg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_bg) begin
			bg_q.out_index   <= idx_s2;
			bg_q.bg_blue     <= use_c1 ? rec_s2.cand1.blue  : rec_s2.cand2.blue;
			bg_q.bg_green    <= use_c1 ? rec_s2.cand1.green : rec_s2.cand2.green;
			bg_q.bg_red      <= use_c1 ? rec_s2.cand1.red   : rec_s2.cand2.red;
			bg_q.was_changed <= rec_s2.changed;
		end
	end

	assign bg_valid = bg_valid_q;
	assign bg       = bg_q;

	// Checks
	`include "background_reconstruction_vote_core_assert.svh"

	`BRV_ASSERT_NOW(a_fwd_matches_mem, valid_s3, mem_q[addr_s3] == rec_s3, "stale forward")
	`BRV_ASSERT_NOW(a_cnt2_needs_cand2, valid_s2, rec_s2.has2 || rec_s2.cnt2 == '0, "orphan count")
	`BRV_ASSERT_NEXT(a_result_loaded, load_bg, bg_valid && bg.out_index == $past(idx_s2), "no item")

endmodule
